// File: sv/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types and constants of the strided, padded depthwise 1-D convolution.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int MAX_CHANNELS_DEF = 256;
    localparam int MAX_TAPS_DEF     = 32;
    localparam int MAX_FRAMES_DEF   = 4096;

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_TAP_COUNT     = 3'd1;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd2;
    localparam logic [2:0] REG_LEFT_PADDING  = 3'd3;
    localparam logic [2:0] REG_RIGHT_PADDING = 3'd4;

    localparam int ACC_W  = 38;
    localparam int FRAC_W = 14;

    typedef struct packed {
        logic [8:0] channel_count;
        logic [5:0] tap_count;
        logic [5:0] step_size;
        logic [4:0] left_padding;
        logic [4:0] right_padding;
    } cfg_t;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
        logic keep;
    } mac_ctrl_t;

endpackage

// File: sv/dwc_cfg.sv
// ----------------------------------------------------------------------------
// dwc_cfg
// APB register file holding the convolution shape registers.
// ----------------------------------------------------------------------------
module dwc_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dwc_pkg::cfg_t     cfg
);

    dwc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= 9'd1;
            cfg_reg.tap_count     <= 6'd1;
            cfg_reg.step_size     <= 6'd1;
            cfg_reg.left_padding  <= 5'd0;
            cfg_reg.right_padding <= 5'd0;
        end else if (wr_en) begin
            case (paddr[4:2])
                dwc_pkg::REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[8:0];
                dwc_pkg::REG_TAP_COUNT:     cfg_reg.tap_count     <= pwdata[5:0];
                dwc_pkg::REG_STEP_SIZE:     cfg_reg.step_size     <= pwdata[5:0];
                dwc_pkg::REG_LEFT_PADDING:  cfg_reg.left_padding  <= pwdata[4:0];
                dwc_pkg::REG_RIGHT_PADDING: cfg_reg.right_padding <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            dwc_pkg::REG_CHANNEL_COUNT: prdata = {23'd0, cfg_reg.channel_count};
            dwc_pkg::REG_TAP_COUNT:     prdata = {26'd0, cfg_reg.tap_count};
            dwc_pkg::REG_STEP_SIZE:     prdata = {26'd0, cfg_reg.step_size};
            dwc_pkg::REG_LEFT_PADDING:  prdata = {27'd0, cfg_reg.left_padding};
            dwc_pkg::REG_RIGHT_PADDING: prdata = {27'd0, cfg_reg.right_padding};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// File: sv/dwc_div.sv
// ----------------------------------------------------------------------------
// dwc_div
// Restoring divider, one quotient bit per cycle, 6-bit divisor.
// ----------------------------------------------------------------------------
module dwc_div #(
    parameter int NW = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [5:0]    divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [5:0]    remainder
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [5:0]      rem_reg, rem_next;
    logic [5:0]      dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [6:0]      trial;

    assign trial = {rem_reg, quo_reg[NW-1]};

    always_comb begin
        quo_next = {quo_reg[NW-2:0], 1'b0};
        rem_next = trial[5:0];
        if (trial >= {1'b0, dvs_reg}) begin
            quo_next[0] = 1'b1;
            rem_next    = 6'(trial - {1'b0, dvs_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/dwc_mac.sv
// ----------------------------------------------------------------------------
// dwc_mac
// Shared multiply-accumulate unit with floor shift and 24-bit saturation.
// ----------------------------------------------------------------------------
module dwc_mac (
    input  logic                aclk,
    input  dwc_pkg::mac_ctrl_t  ctrl,
    input  logic signed [15:0]  sample,
    input  logic signed [15:0]  weight,
    output logic signed [23:0]  result
);

    logic signed [31:0]              prod_reg;
    logic signed [dwc_pkg::ACC_W-1:0] acc_reg;
    logic signed [dwc_pkg::ACC_W-1:0] shifted;

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= ctrl.keep ? sample * weight : 32'sd0;
        end
        if (ctrl.clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc) begin
            acc_reg <= acc_reg + dwc_pkg::ACC_W'(prod_reg);
        end
    end

    assign shifted = acc_reg >>> dwc_pkg::FRAC_W;

    always_comb begin
        if (shifted > dwc_pkg::ACC_W'(8388607)) begin
            result = 24'sh7FFFFF;
        end else if (shifted < -dwc_pkg::ACC_W'(8388608)) begin
            result = 24'sh800000;
        end else begin
            result = shifted[23:0];
        end
    end

endmodule

// File: sv/depthwise_conv1d_strided_padded.sv
// ----------------------------------------------------------------------------
// depthwise_conv1d_strided_padded
// Per-channel strided, zero-padded 1-D convolution over a frame-major stream.
// ----------------------------------------------------------------------------
// After reset the sample history is cleared, one entry per cycle, across all
// MAX_CHANNELS*MAX_TAPS entries (8192 at defaults); s_tready is low meanwhile.
// A weight transfer is written straight into the weight memory. A sample goes,
// for each candidate window (one, or up to right_padding+1 on the last frame,
// right_padding clamped to tap_count-1), through a setup state (S_WIN), the
// serial divider that tests the stride (skipped for a negative position), and,
// when the window is produced, S_RD, S_MUL and S_ACC per tap in the shared
// multiply-accumulate unit, then S_RES to hand the result over and S_NEXT.
// The sample is the only item in flight; results leave via an output register.
// ----------------------------------------------------------------------------
module depthwise_conv1d_strided_padded #(
    parameter int MAX_CHANNELS = dwc_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_TAPS     = dwc_pkg::MAX_TAPS_DEF,
    parameter int MAX_FRAMES   = dwc_pkg::MAX_FRAMES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[7:0], tap[12:8], value[28:13]
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_frame[11:0], out_channel[19:12], out_value[43:20]
    output logic        m_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_CHANNELS * MAX_TAPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int DW    = FW + 8;
    localparam int NW    = DW - 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WIN  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_RES  = 4'd7;
    localparam logic [3:0] S_NEXT = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    dwc_pkg::cfg_t     cfg;
    dwc_pkg::mac_ctrl_t mac_ctrl;

    logic [7:0]         in_channel;
    logic [4:0]         in_tap;
    logic signed [15:0] in_value;

    logic [11:0] c_eff;
    logic [6:0]  k_eff, km1;
    logic [5:0]  s_eff;
    logic [6:0]  pl_eff, pr_eff;

    logic [3:0]          state_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [FW-1:0]       fc_reg, t_reg;
    logic [TW-1:0]       tm_reg, ts_reg;
    logic [AW-1:0]       base_reg;
    logic [7:0]          ch_reg;
    logic [4:0]          i_reg, extra_reg;
    logic [TW-1:0]       j_reg;
    logic signed [7:0]   off_reg;
    logic                keep_reg;
    logic [NW-1:0]       q_reg;
    logic signed [15:0]  hist_q_reg, w_q_reg;

    logic                pend_valid_reg;
    logic [11:0]         pend_frame_reg;
    logic [23:0]         pend_value_reg;
    logic                out_valid_reg;
    logic [47:0]         out_data_reg;
    logic                out_last_reg;

    logic signed [15:0]  hist_mem [DEPTH];
    logic signed [15:0]  w_mem    [DEPTH];

    logic                accept, is_weight, ch_ok, w_ok;
    logic signed [DW-1:0] d_val, fpos;
    logic signed [8:0]   slot_raw;
    logic [TW-1:0]       slot;
    logic                tap_ok;
    logic                out_free;
    logic                div_start, div_done;
    logic [NW-1:0]       div_q;
    logic [5:0]          div_r;
    logic signed [23:0]  mac_result;
    logic [NW+11:0]      q_ext;
    logic [AW-1:0]       acc_addr;

    assign in_channel = s_tdata[7:0];
    assign in_tap     = s_tdata[12:8];
    assign in_value   = s_tdata[28:13];
    assign is_weight  = s_tuser;

    // effective register values
    always_comb begin
        if (cfg.channel_count == 9'd0) begin
            c_eff = 12'd1;
        end else if ({3'd0, cfg.channel_count} > 12'(MAX_CHANNELS)) begin
            c_eff = 12'(MAX_CHANNELS);
        end else begin
            c_eff = {3'd0, cfg.channel_count};
        end
        if (cfg.tap_count == 6'd0) begin
            k_eff = 7'd1;
        end else if ({1'b0, cfg.tap_count} > 7'(MAX_TAPS)) begin
            k_eff = 7'(MAX_TAPS);
        end else begin
            k_eff = {1'b0, cfg.tap_count};
        end
        km1    = k_eff - 7'd1;
        s_eff  = (cfg.step_size == 6'd0) ? 6'd1 : cfg.step_size;
        pl_eff = ({2'd0, cfg.left_padding} > km1) ? km1 : {2'd0, cfg.left_padding};
        pr_eff = ({2'd0, cfg.right_padding} > km1) ? km1 : {2'd0, cfg.right_padding};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign ch_ok    = {4'd0, in_channel} < c_eff;
    assign w_ok     = ({4'd0, in_channel} < 12'(MAX_CHANNELS)) &&
                      ({2'd0, in_tap} < 7'(MAX_TAPS));
    assign acc_addr = AW'(in_channel) * AW'(MAX_TAPS);

    assign d_val = $signed({{(DW-FW){1'b0}}, t_reg}) + $signed(DW'(i_reg))
                 + $signed(DW'(pl_eff)) - $signed(DW'(km1));
    assign fpos  = $signed({{(DW-FW){1'b0}}, t_reg}) + DW'(off_reg);
    assign tap_ok = (off_reg <= 8'sd0) && (fpos >= 0);
    // window frame offset is measured from the slot of the sample's own frame
    assign slot_raw = $signed({{(9-TW){1'b0}}, ts_reg}) + 9'(off_reg);
    assign slot = (slot_raw < 0) ? TW'(slot_raw + 9'(MAX_TAPS)) : TW'(slot_raw);

    assign out_free  = !out_valid_reg || m_tready;
    assign div_start = (state_reg == S_WIN) && (d_val >= 0);
    assign q_ext     = {12'd0, q_reg};

    always_comb begin
        mac_ctrl.clr  = (state_reg == S_DIV) && div_done && (div_r == 6'd0);
        mac_ctrl.mul  = (state_reg == S_MUL);
        mac_ctrl.acc  = (state_reg == S_ACC);
        mac_ctrl.keep = keep_reg;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLR) begin
            hist_mem[clr_cnt_reg] <= 16'sd0;
        end else if (accept && !is_weight && ch_ok) begin
            hist_mem[acc_addr + AW'(tm_reg)] <= in_value;
        end
        if (state_reg == S_RD) begin
            hist_q_reg <= hist_mem[base_reg + AW'(slot)];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_weight && w_ok) begin
            w_mem[acc_addr + AW'(in_tap)] <= in_value;
        end
        if (state_reg == S_RD) begin
            w_q_reg <= w_mem[base_reg + AW'(j_reg)];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            fc_reg         <= '0;
            tm_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && !is_weight && ch_ok) begin
                        t_reg     <= fc_reg;
                        ts_reg    <= tm_reg;
                        ch_reg    <= in_channel;
                        base_reg  <= acc_addr;
                        i_reg     <= 5'd0;
                        extra_reg <= s_tlast ? pr_eff[4:0] : 5'd0;
                        state_reg <= S_WIN;
                        if ({4'd0, in_channel} == c_eff - 12'd1) begin
                            if (s_tlast || fc_reg == FW'(MAX_FRAMES - 1)) begin
                                fc_reg <= '0;
                                tm_reg <= '0;
                            end else begin
                                fc_reg <= fc_reg + 1'b1;
                                tm_reg <= (tm_reg == TW'(MAX_TAPS - 1)) ? '0 : tm_reg + 1'b1;
                            end
                        end
                    end
                end
                S_WIN: begin
                    off_reg   <= 8'(i_reg) - 8'(km1);
                    j_reg     <= '0;
                    state_reg <= (d_val >= 0) ? S_DIV : S_NEXT;
                end
                S_DIV: begin
                    if (div_done) begin
                        q_reg     <= div_q;
                        state_reg <= (div_r == 6'd0) ? S_RD : S_NEXT;
                    end
                end
                S_RD: begin
                    keep_reg  <= tap_ok;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if ({{(7-TW){1'b0}}, j_reg} == km1) begin
                        state_reg <= S_RES;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        off_reg   <= off_reg + 8'sd1;
                        state_reg <= S_RD;
                    end
                end
                S_RES: begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                            out_data_reg  <= {4'd0, pend_value_reg, ch_reg, pend_frame_reg};
                        end
                        pend_valid_reg <= 1'b1;
                        pend_frame_reg <= q_ext[11:0];
                        pend_value_reg <= mac_result;
                        state_reg      <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (i_reg == extra_reg) begin
                        state_reg <= S_FIN;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_WIN;
                    end
                end
                S_FIN: begin
                    if (!pend_valid_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        out_data_reg   <= {4'd0, pend_value_reg, ch_reg, pend_frame_reg};
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    dwc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dwc_div #(
        .NW (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (d_val[NW-1:0]),
        .divisor   (s_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    dwc_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sample (hist_q_reg),
        .weight (w_q_reg),
        .result (mac_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_ready_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("input ready while a result is pending");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_last_tap_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC && {{(7-TW){1'b0}}, j_reg} == km1) |=> (state_reg == S_RES))
        else $error("accumulation did not end after the last tap");

endmodule
